/* hdl/voxel_face_mesher_with_ao_macros.svh */
// ----------------------------------------------------------------------------
// Voxel face mesher assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VOXEL_FACE_MESHER_WITH_AO_MACROS_SVH
`define VOXEL_FACE_MESHER_WITH_AO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFM_CHECK(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("vfm check failed");

// The consequent must hold in the cycle after the antecedent.
`define VFM_CHECK_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("vfm check failed");

`endif

/* hdl/vfm_pkg.sv */
// ----------------------------------------------------------------------------
// Voxel face mesher package
// Widths, register indexes, face codes, geometry tables and the queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package vfm_pkg;

    localparam int CHUNK_SIDE  = 16;
    localparam int LAYER_COUNT = 64;

    localparam int X_W    = 4;
    localparam int Y_W    = 6;
    localparam int Z_W    = 4;
    localparam int ID_W   = 8;
    localparam int MASK_W = 27;
    localparam int WORD_W = 31;
    localparam int CX_W   = 12;
    localparam int CZ_W   = 12;
    localparam int WC_W   = 13;
    localparam int WX_W   = 18;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_Z      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_CHUNKS = 2'd2;

    localparam logic [WC_W-1:0] WORLD_CHUNKS_RESET = 13'd16;

    localparam int NUM_FACES    = 6;
    localparam int VTX_PER_FACE = 6;
    localparam int FACE_W       = 3;
    localparam int VTX_W        = 3;
    localparam int AO_W         = 2;

    localparam logic [VTX_W-1:0] VTX_LAST = VTX_W'(VTX_PER_FACE - 1);

    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd1;
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd3;
    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd4;
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int FACE_OFF [NUM_FACES][3] = '{
        '{0, 1, 0}, '{0, -1, 0}, '{1, 0, 0}, '{-1, 0, 0}, '{0, 0, 1}, '{0, 0, -1}
    };

    localparam int FACE_PLANE [NUM_FACES] = '{0, 0, 1, 1, 2, 2};

    localparam int PLANE_RING [3][8][3] = '{
        '{'{0,0,-1}, '{1,0,-1}, '{1,0,0}, '{1,0,1},
          '{0,0,1}, '{-1,0,1}, '{-1,0,0}, '{-1,0,-1}},
        '{'{0,1,0}, '{0,1,-1}, '{0,0,-1}, '{0,-1,-1},
          '{0,-1,0}, '{0,-1,1}, '{0,0,1}, '{0,1,1}},
        '{'{0,1,0}, '{1,1,0}, '{1,0,0}, '{1,-1,0},
          '{0,-1,0}, '{-1,-1,0}, '{-1,0,0}, '{-1,1,0}}
    };

    typedef struct packed {
        logic            cx;
        logic            cy;
        logic            cz;
        logic [AO_W-1:0] aoi;
    } t_corner;

    localparam t_corner CORNER_TAB [NUM_FACES][4] = '{
        '{'{1'b1, 1'b1, 1'b0, 2'd0}, '{1'b1, 1'b1, 1'b1, 2'd1},
          '{1'b0, 1'b1, 1'b1, 2'd2}, '{1'b0, 1'b1, 1'b0, 2'd3}},
        '{'{1'b1, 1'b0, 1'b1, 2'd3}, '{1'b1, 1'b0, 1'b0, 2'd2},
          '{1'b0, 1'b0, 1'b0, 2'd1}, '{1'b0, 1'b0, 1'b1, 2'd0}},
        '{'{1'b1, 1'b1, 1'b0, 2'd0}, '{1'b1, 1'b0, 1'b0, 2'd1},
          '{1'b1, 1'b0, 1'b1, 2'd2}, '{1'b1, 1'b1, 1'b1, 2'd3}},
        '{'{1'b0, 1'b1, 1'b1, 2'd3}, '{1'b0, 1'b0, 1'b1, 2'd2},
          '{1'b0, 1'b0, 1'b0, 2'd1}, '{1'b0, 1'b1, 1'b0, 2'd0}},
        '{'{1'b1, 1'b1, 1'b1, 2'd0}, '{1'b1, 1'b0, 1'b1, 2'd1},
          '{1'b0, 1'b0, 1'b1, 2'd2}, '{1'b0, 1'b1, 1'b1, 2'd3}},
        '{'{1'b0, 1'b1, 1'b0, 2'd3}, '{1'b0, 1'b0, 1'b0, 2'd2},
          '{1'b1, 1'b0, 1'b0, 2'd1}, '{1'b1, 1'b1, 1'b0, 2'd0}}
    };

    localparam logic [1:0] ORDER_PLAIN [VTX_PER_FACE] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};
    localparam logic [1:0] ORDER_FLIP  [VTX_PER_FACE] = '{2'd1, 2'd2, 2'd3, 2'd1, 2'd3, 2'd0};

    typedef struct packed {
        logic [X_W-1:0]                        x;
        logic [Y_W-1:0]                        y;
        logic [Z_W-1:0]                        z;
        logic [ID_W-1:0]                       id;
        logic [NUM_FACES-1:0]                  open;
        logic [NUM_FACES-1:0][3:0][AO_W-1:0]   ao;
        logic [NUM_FACES-1:0]                  flip;
    } t_job;

    function automatic logic cell_void(input logic [MASK_W-1:0] mask,
                                       input logic [Y_W-1:0] y,
                                       input int dx, input int dy, input int dz);
        int ly;
        int idx;
        ly  = int'(y) + dy;
        idx = (dy + 1) * 9 + (dz + 1) * 3 + (dx + 1);
        if (ly < 0 || ly >= LAYER_COUNT) begin
            return 1'b1;
        end
        return !mask[idx[4:0]];
    endfunction

endpackage

`default_nettype wire

/* hdl/voxel_face_mesher_with_ao.sv */
// ----------------------------------------------------------------------------
// Voxel face mesher with ambient occlusion
// Culled voxel face meshing with per-corner occlusion, top level.
// ----------------------------------------------------------------------------
// The front end takes one voxel per cycle while its four-entry job queue has
// room, and voxels with id zero or no exposed face are dropped there at no
// further cost. The back end emits one vertex word per cycle while its output
// is popped or empty, six words for each exposed face of a voxel; the vertex
// output port sets the sustained rate. The first word of a voxel is written
// into the job queue and then into the registered output word.
`default_nettype none

module voxel_face_mesher_with_ao
    import vfm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [X_W-1:0]        i_x_pos,
    input  wire logic [Y_W-1:0]        i_y_pos,
    input  wire logic [Z_W-1:0]        i_z_pos,
    input  wire logic [ID_W-1:0]       i_voxel_id,
    input  wire logic [MASK_W-1:0]     i_neighbor_mask,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [WORD_W-1:0]          o_vertex_word,
    output logic                       o_last
);

    t_job w_job;
    t_job w_head_job;
    logic w_wr;
    logic w_rd;
    logic w_head_valid;

    vfm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (push && !full),
        .i_x_pos         (i_x_pos),
        .i_y_pos         (i_y_pos),
        .i_z_pos         (i_z_pos),
        .i_voxel_id      (i_voxel_id),
        .i_neighbor_mask (i_neighbor_mask),
        .o_job           (w_job),
        .o_wr            (w_wr)
    );

    vfm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (w_wr),
        .i_wr_job     (w_job),
        .o_full       (full),
        .i_rd         (w_rd),
        .o_head_valid (w_head_valid),
        .o_head_job   (w_head_job)
    );

    vfm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_head_valid),
        .i_head_job    (w_head_job),
        .o_rd          (w_rd),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_vertex_word (o_vertex_word),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

/* hdl/vfm_front.sv */
// ----------------------------------------------------------------------------
// Voxel face mesher front end
// Holds the chunk registers, finds exposed faces and their corner occlusion.
// ----------------------------------------------------------------------------
`default_nettype none

module vfm_front
    import vfm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_accept,
    input  wire logic [X_W-1:0]        i_x_pos,
    input  wire logic [Y_W-1:0]        i_y_pos,
    input  wire logic [Z_W-1:0]        i_z_pos,
    input  wire logic [ID_W-1:0]       i_voxel_id,
    input  wire logic [MASK_W-1:0]     i_neighbor_mask,
    output t_job                       o_job,
    output logic                       o_wr
);

    logic [CX_W-1:0] r_chunk_x;
    logic [CZ_W-1:0] r_chunk_z;
    logic [WC_W-1:0] r_world_chunks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_x      <= '0;
            r_chunk_z      <= '0;
            r_world_chunks <= WORLD_CHUNKS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CHUNK_X:      r_chunk_x      <= i_cfg_data[CX_W-1:0];
                REG_CHUNK_Z:      r_chunk_z      <= i_cfg_data[CZ_W-1:0];
                REG_WORLD_CHUNKS: r_world_chunks <= i_cfg_data[WC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // World coordinate plus one is compared with the scaled width, which
    // avoids a negative border when the width is zero.
    logic [WX_W-1:0] w_wx_p1;
    logic [WX_W-1:0] w_wz_p1;
    logic [WX_W-1:0] w_far;
    logic            w_x_far;
    logic            w_x_zero;
    logic            w_z_far;
    logic            w_z_zero;
    logic [NUM_FACES-1:0] w_void;

    assign w_wx_p1  = WX_W'(r_chunk_x) * WX_W'(CHUNK_SIDE) + WX_W'(i_x_pos) + WX_W'(1);
    assign w_wz_p1  = WX_W'(r_chunk_z) * WX_W'(CHUNK_SIDE) + WX_W'(i_z_pos) + WX_W'(1);
    assign w_far    = WX_W'(r_world_chunks) * WX_W'(CHUNK_SIDE);
    assign w_x_far  = (w_wx_p1 == w_far);
    assign w_z_far  = (w_wz_p1 == w_far);
    assign w_x_zero = (i_x_pos == '0) && (r_chunk_x == '0);
    assign w_z_zero = (i_z_pos == '0) && (r_chunk_z == '0);

    for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
        logic [7:0]      w_ring;
        logic [AO_W-1:0] w_ao0;
        logic [AO_W-1:0] w_ao1;
        logic [AO_W-1:0] w_ao2;
        logic [AO_W-1:0] w_ao3;

        assign w_void[f] = cell_void(i_neighbor_mask, i_y_pos,
                                     FACE_OFF[f][0], FACE_OFF[f][1], FACE_OFF[f][2]);

        for (genvar k = 0; k < 8; k++) begin : g_ring
            assign w_ring[k] = cell_void(i_neighbor_mask, i_y_pos,
                FACE_OFF[f][0] + PLANE_RING[FACE_PLANE[f]][k][0],
                FACE_OFF[f][1] + PLANE_RING[FACE_PLANE[f]][k][1],
                FACE_OFF[f][2] + PLANE_RING[FACE_PLANE[f]][k][2]);
        end

        assign w_ao0 = AO_W'(w_ring[0]) + AO_W'(w_ring[1]) + AO_W'(w_ring[2]);
        assign w_ao1 = AO_W'(w_ring[2]) + AO_W'(w_ring[3]) + AO_W'(w_ring[4]);
        assign w_ao2 = AO_W'(w_ring[4]) + AO_W'(w_ring[5]) + AO_W'(w_ring[6]);
        assign w_ao3 = AO_W'(w_ring[6]) + AO_W'(w_ring[7]) + AO_W'(w_ring[0]);

        assign o_job.ao[f][0] = w_ao0;
        assign o_job.ao[f][1] = w_ao1;
        assign o_job.ao[f][2] = w_ao2;
        assign o_job.ao[f][3] = w_ao3;
        assign o_job.flip[f]  = (3'(w_ao3) + 3'(w_ao1)) > (3'(w_ao0) + 3'(w_ao2));
    end

    assign o_job.open[FACE_TOP]    = w_void[FACE_TOP] ||
                                     (i_y_pos == Y_W'(LAYER_COUNT - 1));
    assign o_job.open[FACE_BOTTOM] = w_void[FACE_BOTTOM] && (i_y_pos != '0);
    assign o_job.open[FACE_RIGHT]  = w_void[FACE_RIGHT] && !w_x_far;
    assign o_job.open[FACE_LEFT]   = w_void[FACE_LEFT] && !w_x_zero;
    assign o_job.open[FACE_FRONT]  = w_void[FACE_FRONT] && !w_z_far;
    assign o_job.open[FACE_BACK]   = w_void[FACE_BACK] && !w_z_zero;

    assign o_job.x  = i_x_pos;
    assign o_job.y  = i_y_pos;
    assign o_job.z  = i_z_pos;
    assign o_job.id = i_voxel_id;

    assign o_wr = i_accept && (i_voxel_id != '0) && (o_job.open != '0);

endmodule

`default_nettype wire

/* hdl/vfm_queue.sv */
// ----------------------------------------------------------------------------
// Voxel face mesher job queue
// Small first-in first-out buffer of face jobs between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vfm_queue
    import vfm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_job i_wr_job,
    output logic      o_full,
    input  wire logic i_rd,
    output logic      o_head_valid,
    output t_job      o_head_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_job   = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

/* hdl/vfm_back.sv */
// ----------------------------------------------------------------------------
// Voxel face mesher back end
// Walks the exposed faces of the head job and emits six vertex words each.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voxel_face_mesher_with_ao_macros.svh"

module vfm_back
    import vfm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_head_valid,
    input  wire t_job              i_head_job,
    output logic                   o_rd,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic [WORD_W-1:0]      o_vertex_word,
    output logic                   o_last
);

    logic [NUM_FACES-1:0] r_done;
    logic [VTX_W-1:0]     r_vtx;
    logic                 r_out_valid;
    logic [WORD_W-1:0]    r_out_word;
    logic                 r_out_last;

    logic [NUM_FACES-1:0] w_remain;
    logic [NUM_FACES-1:0] w_sel_oh;
    logic [FACE_W-1:0]    w_face;
    logic                 w_found;
    logic                 w_face_last;
    logic                 w_step;
    logic                 w_flip;
    logic [1:0]           w_corner_idx;
    t_corner              w_corner;
    logic [AO_W-1:0]      w_ao;
    logic [WORD_W-1:0]    n_out_word;
    logic                 n_out_last;

    assign w_remain = i_head_job.open & ~r_done;

    always_comb begin
        w_sel_oh = '0;
        w_face   = '0;
        w_found  = 1'b0;
        for (int i = 0; i < NUM_FACES; i++) begin
            if (!w_found && w_remain[i]) begin
                w_found     = 1'b1;
                w_sel_oh[i] = 1'b1;
                w_face      = FACE_W'(i);
            end
        end
    end

    assign w_face_last  = ((w_remain & ~w_sel_oh) == '0);
    assign w_step       = i_head_valid && (!r_out_valid || i_pop);
    assign w_flip       = i_head_job.flip[w_face];
    assign w_corner_idx = w_flip ? ORDER_FLIP[r_vtx] : ORDER_PLAIN[r_vtx];
    assign w_corner     = CORNER_TAB[w_face][w_corner_idx];
    assign w_ao         = i_head_job.ao[w_face][w_corner.aoi];

    assign n_out_word = {5'(i_head_job.x) + 5'(w_corner.cx),
                         7'(i_head_job.y) + 7'(w_corner.cy),
                         5'(i_head_job.z) + 5'(w_corner.cz),
                         i_head_job.id, w_face, w_ao, w_flip};
    assign n_out_last = (r_vtx == VTX_LAST) && w_face_last;

    assign o_rd = w_step && n_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_vtx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_out_valid <= 1'b1;
                if (r_vtx == VTX_LAST) begin
                    r_vtx  <= '0;
                    r_done <= w_face_last ? '0 : (r_done | w_sel_oh);
                end else begin
                    r_vtx <= r_vtx + 1'b1;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_word <= n_out_word;
            r_out_last <= n_out_last;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_vertex_word = r_out_word;
    assign o_last        = r_out_last;

    `VFM_CHECK(a_vtx_range, 1'b1, r_vtx <= VTX_LAST)
    `VFM_CHECK(a_rd_at_end, o_rd, (r_vtx == VTX_LAST) && w_face_last && w_found)
    `VFM_CHECK_NEXT(a_last_after_rd, o_rd, r_out_valid && r_out_last)
    `VFM_CHECK(a_done_subset, i_head_valid, (r_done & ~i_head_job.open) == '0)

endmodule

`default_nettype wire
